@@ hw/rtl/tla_pkg.sv @@
// ----------------------------------------------------------------------------
// tla_pkg
// Shared constants, opcodes and controller/datapath signal groups for the
// toroidal Life automaton.
// ----------------------------------------------------------------------------
`default_nettype none

package tla_pkg;

    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    localparam int OPCODE_W = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the request item
        logic rd_en;     // read one row of the live bank
        logic rd_item;   // read address from the item row, else from controller
        logic shift;     // shift read data into the three-row window
        logic wr_cell;   // write back the row with one cell replaced
        logic wr_clear;  // write a zero row into the live bank
        logic wr_gen;    // write the next-generation row into the spare bank
        logic flip;      // swap live and spare banks
        logic res_load;  // load the result register
    } tla_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                on_board;
    } tla_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tla_if.sv @@
// ----------------------------------------------------------------------------
// tla_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tla_req_if;
    logic                          valid;
    logic                          ready;
    logic [tla_pkg::OPCODE_W-1:0]  opcode;
    logic [tla_pkg::ROW_W-1:0]     row;
    logic [tla_pkg::COL_W-1:0]     col;
    logic                          cell_in;

    modport source (output valid, output opcode, output row, output col, output cell_in,
                    input ready);
    modport sink   (input valid, input opcode, input row, input col, input cell_in,
                    output ready);
endinterface

interface tla_rsp_if;
    logic valid;
    logic ready;
    logic cell_out;
    logic done_res;

    modport source (output valid, output cell_out, output done_res, input ready);
    modport sink   (input valid, input cell_out, input done_res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tla_datapath.sv @@
// ----------------------------------------------------------------------------
// tla_datapath
// Two-bank row-organised board memory, item registers, three-row window and
// the per-column next-generation logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_datapath #(
    parameter int GRID_ROWS = tla_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = tla_pkg::GRID_COLS_DEF,
    localparam int RW = $clog2(GRID_ROWS),
    localparam int CLW = $clog2(GRID_COLS)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tla_pkg::tla_cmd_t            cmd,
    input  wire logic [RW-1:0]                rd_row,
    input  wire logic [RW-1:0]                wr_row,
    output      tla_pkg::tla_status_t         status,
    input  wire logic [tla_pkg::OPCODE_W-1:0] opcode,
    input  wire logic [tla_pkg::ROW_W-1:0]    row,
    input  wire logic [tla_pkg::COL_W-1:0]    col,
    input  wire logic                         cell_in,
    output      logic                         cell_out
);

    localparam int DEPTH = 2 * (1 << RW);

    logic [GRID_COLS-1:0] mem [DEPTH];

    logic [tla_pkg::OPCODE_W-1:0] opcode_reg;
    logic [tla_pkg::ROW_W-1:0]    row_reg;
    logic [tla_pkg::COL_W-1:0]    col_reg;
    logic                         cell_in_reg;
    logic                         bank_sel_reg;
    logic [GRID_COLS-1:0]         rd_data_reg;
    logic [GRID_COLS-1:0]         win_top_reg;
    logic [GRID_COLS-1:0]         win_mid_reg;
    logic [GRID_COLS-1:0]         win_bot_reg;
    logic                         cell_out_reg;
    logic                         cell_out_next;

    logic                 on_board;
    logic [RW-1:0]        item_row;
    logic [CLW-1:0]       item_col;
    logic [RW:0]          rd_addr;
    logic [RW:0]          wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic                 wr_en;
    logic [GRID_COLS-1:0] row_mod;
    logic [GRID_COLS-1:0] gen_row;

    assign on_board = (32'(row_reg) < GRID_ROWS) && (32'(col_reg) < GRID_COLS);
    assign item_row = RW'(row_reg);
    assign item_col = CLW'(col_reg);

    assign status.opcode   = opcode_reg;
    assign status.on_board = on_board;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg  <= opcode;
            row_reg     <= row;
            col_reg     <= col;
            cell_in_reg <= cell_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bank_sel_reg <= 1'b0;
        else if (cmd.flip)
            bank_sel_reg <= ~bank_sel_reg;
    end

    // Board memory: one read and one write port, registered read data
    assign rd_addr = {bank_sel_reg, (cmd.rd_item ? item_row : rd_row)};

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_comb
    begin
        row_mod           = rd_data_reg;
        row_mod[item_col] = cell_in_reg;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {bank_sel_reg, wr_row};
        wr_data = '0;
        if (cmd.wr_cell)
        begin
            wr_en   = on_board;
            wr_addr = {bank_sel_reg, item_row};
            wr_data = row_mod;
        end
        else if (cmd.wr_clear)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_gen)
        begin
            wr_en   = 1'b1;
            wr_addr = {~bank_sel_reg, wr_row};
            wr_data = gen_row;
        end
    end

    // Rows r-1, r, r+1 of the live board
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            win_top_reg <= win_mid_reg;
            win_mid_reg <= win_bot_reg;
            win_bot_reg <= rd_data_reg;
        end
    end

    for (genvar j = 0; j < GRID_COLS; j++)
    begin : g_lane
        localparam int L = (j == 0) ? GRID_COLS - 1 : j - 1;
        localparam int R = (j == GRID_COLS - 1) ? 0 : j + 1;
        logic [3:0] nbrs;
        assign nbrs = 4'(win_top_reg[L]) + 4'(win_top_reg[j]) + 4'(win_top_reg[R])
                    + 4'(win_mid_reg[L]) + 4'(win_mid_reg[R])
                    + 4'(win_bot_reg[L]) + 4'(win_bot_reg[j]) + 4'(win_bot_reg[R]);
        assign gen_row[j] = win_mid_reg[j] ? ((nbrs == 4'd2) || (nbrs == 4'd3))
                                           : (nbrs == 4'd3);
    end

    assign cell_out_next = (opcode_reg == tla_pkg::OP_READ) && on_board
                           && rd_data_reg[item_col];

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
            cell_out_reg <= cell_out_next;
    end

    assign cell_out = cell_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tla_controller.sv @@
// ----------------------------------------------------------------------------
// tla_controller
// Sequencer for reset clearing, cell access, board clear and generation
// sweep; owns the handshakes and the response valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_controller #(
    parameter int GRID_ROWS = tla_pkg::GRID_ROWS_DEF,
    localparam int RW = $clog2(GRID_ROWS),
    localparam int CW = $clog2(GRID_ROWS + 4)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output      logic                 req_ready,
    output      logic                 rsp_valid,
    input  wire logic                 rsp_ready,
    output      tla_pkg::tla_cmd_t    cmd,
    output      logic [RW-1:0]        rd_row,
    output      logic [RW-1:0]        wr_row,
    input  wire tla_pkg::tla_status_t status
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_RMW    = 3'd3;
    localparam logic [2:0] S_CLR    = 3'd4;
    localparam logic [2:0] S_GEN    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          shift_pend_reg, shift_pend_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          out_free;
    logic          last_row;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign last_row = (cnt_reg == CW'(GRID_ROWS - 1));
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_row         = '0;
        wr_row         = '0;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            S_INIT, S_CLR:
            begin
                cmd.wr_clear = 1'b1;
                wr_row       = RW'(cnt_reg);
                cnt_next     = cnt_reg + CW'(1);
                if (last_row)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_FIN;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                case (status.opcode)
                    tla_pkg::OP_WRITE, tla_pkg::OP_READ:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_item = 1'b1;
                        state_next  = S_RMW;
                    end
                    tla_pkg::OP_CLEAR: state_next = S_CLR;
                    tla_pkg::OP_STEP:  state_next = S_GEN;
                    default:           state_next = S_FIN;
                endcase
            end
            S_RMW:
            begin
                cmd.wr_cell = (status.opcode == tla_pkg::OP_WRITE) && status.on_board;
                state_next  = S_FIN;
            end
            S_GEN:
            begin
                // read rows R-1, 0, 1 .. R-1, 0; write row cnt-4 from the window
                cmd.rd_en  = (cnt_reg <= CW'(GRID_ROWS + 1));
                if (cnt_reg == '0)
                    rd_row = RW'(GRID_ROWS - 1);
                else if (cnt_reg == CW'(GRID_ROWS + 1))
                    rd_row = '0;
                else
                    rd_row = RW'(cnt_reg - CW'(1));
                cmd.shift  = shift_pend_reg;
                cmd.wr_gen = (cnt_reg >= CW'(4));
                wr_row     = RW'(cnt_reg - CW'(4));
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(GRID_ROWS + 3))
                begin
                    cmd.flip   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign shift_pend_next = (state_reg == S_GEN) && cmd.rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            shift_pend_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            shift_pend_reg <= shift_pend_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/toroidal_life_automaton_top.sv @@
// Accept to response valid: a write/read cell passes the decode, read-modify-write and
// finish states; a board clear writes a zero row to each of the GRID_ROWS rows first.
// One item in flight at a time; a generation runs at one board row per cycle, set by
// the single row read port of the board memory.
// A finished response may wait in the output register while the next item is taken.
// Reset: asynchronous; a clearing pass over the GRID_ROWS rows follows with ready low.
// ----------------------------------------------------------------------------
// toroidal_life_automaton_top
// Game of Life on a wrap-around board with cell write/read, clear and step.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_life_automaton_top #(
    parameter int GRID_ROWS = tla_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = tla_pkg::GRID_COLS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    tla_req_if.sink  req,
    tla_rsp_if.source rsp
);

    localparam int RW = $clog2(GRID_ROWS);

    tla_pkg::tla_cmd_t    cmd;
    tla_pkg::tla_status_t status;
    logic [RW-1:0]        rd_row;
    logic [RW-1:0]        wr_row;
    logic                 req_ready;
    logic                 rsp_valid;
    logic                 cell_out;

    tla_controller #(
        .GRID_ROWS (GRID_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .rd_row    (rd_row),
        .wr_row    (wr_row),
        .status    (status)
    );

    tla_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_row   (rd_row),
        .wr_row   (wr_row),
        .status   (status),
        .opcode   (req.opcode),
        .row      (req.row),
        .col      (req.col),
        .cell_in  (req.cell_in),
        .cell_out (cell_out)
    );

    assign req.ready    = req_ready;
    assign rsp.valid    = rsp_valid;
    assign rsp.cell_out = cell_out;
    assign rsp.done_res = 1'b1;

endmodule

`default_nettype wire

@@ hw/rtl/tla_checker.sv @@
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks on the request/response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_cell_out,
    input wire logic rsp_done_res
);

    logic [1:0] pend_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // items accepted whose response has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_reg + 2'(req_fire) - 2'(rsp_fire);
    end

    a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_done_res)
        else $error("response without done flag");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_out))
        else $error("stalled response changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("request taken while previous item still in work");

    a_rsp_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pend_reg != 2'd0))
        else $error("response with no item outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items outstanding");

endmodule

bind toroidal_life_automaton_top tla_checker u_tla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_cell_out (rsp.cell_out),
    .rsp_done_res (rsp.done_res)
);

`default_nettype wire

@@ sim/toroidal_life_automaton_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_automaton_top_test
// Drives cell writes, reads, board clears and generation steps into the
// wrap-around Life board. A board model inside the bench predicts each
// response, which is checked in order. Both channels see random idle gaps.
// ----------------------------------------------------------------------------

module toroidal_life_automaton_top_test;
    import tla_pkg::*;

    localparam int ROWS          = GRID_ROWS_DEF;
    localparam int COLS          = GRID_COLS_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 90;

    typedef struct packed {
        logic cell_out;
        logic done_res;
    } life_answer_t;

    logic clk;
    logic rst_n;

    tla_req_if req_ch ();
    tla_rsp_if rsp_ch ();

    toroidal_life_automaton_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bit [COLS-1:0] life_grid [ROWS];
    life_answer_t  pending_answers [$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            ready_hold     = 0;
    int            items_sent     = 0;
    bit            steady_flow    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // board model
    // ------------------------------------------------------------------
    function automatic void life_generation();
        bit [COLS-1:0] nxt [ROWS];
        int            nbrs;
        int            rr;
        int            cc;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                        begin
                            rr = (r + dr + ROWS) % ROWS;
                            cc = (c + dc + COLS) % COLS;
                            nbrs += life_grid[rr][cc];
                        end
                    end
                end
                nxt[r][c] = life_grid[r][c];
                if (life_grid[r][c] && (nbrs < 2 || nbrs > 3))
                    nxt[r][c] = 1'b0;
                else if (!life_grid[r][c] && nbrs == 3)
                    nxt[r][c] = 1'b1;
            end
        end
        life_grid = nxt;
    endfunction

    function automatic life_answer_t life_apply(input logic [OPCODE_W-1:0] op,
                                                input logic [ROW_W-1:0]    row,
                                                input logic [COL_W-1:0]    col,
                                                input logic                alive);
        life_answer_t ans;
        bit           on_board;
        ans.cell_out = 1'b0;
        ans.done_res = 1'b1;
        on_board = (int'(row) < ROWS) && (int'(col) < COLS);
        case (op)
            OP_WRITE: if (on_board) life_grid[row][col] = alive;
            OP_CLEAR: foreach (life_grid[r]) life_grid[r] = '0;
            OP_STEP:  life_generation();
            OP_READ:  if (on_board) ans.cell_out = life_grid[row][col];
            default:  ;
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // item driver
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [OPCODE_W-1:0] op, input int row, input int col,
                             input logic alive);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (req_ch.valid)
                req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.row     <= row[ROW_W-1:0];
        req_ch.col     <= col[COL_W-1:0];
        req_ch.cell_in <= alive;
        do @(posedge clk); while (!req_ch.ready);
        pending_answers.push_back(life_apply(op, row[ROW_W-1:0], col[COL_W-1:0], alive));
        items_sent++;
    endtask

    task automatic wait_drained();
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
    endtask

    // response ready: mostly high, short stalls, the odd long one
    always @(posedge clk)
    begin
        if (steady_flow)
            rsp_ch.ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(10, 40);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // response checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_answers
        life_answer_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response item with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.cell_out !== want.cell_out)
                begin
                    $error("cell_out: expected %0b, got %0b", want.cell_out, rsp_ch.cell_out);
                    mismatch_count++;
                end
                if (rsp_ch.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0b, got %0b", want.done_res, rsp_ch.done_res);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_board();
        send_item(OP_READ, 0, 0, 1'b0);
        send_item(OP_READ, ROWS - 1, COLS - 1, 1'b1);
        send_item(OP_READ, 0, COLS - 1, 1'b0);
        send_item(OP_READ, ROWS - 1, 0, 1'b1);
    endtask

    task automatic test_cell_access();
        send_item(OP_WRITE, 0, 0, 1'b1);
        send_item(OP_WRITE, ROWS - 1, COLS - 1, 1'b1);
        send_item(OP_WRITE, 0, COLS - 1, 1'b1);
        send_item(OP_WRITE, ROWS - 1, 0, 1'b1);
        send_item(OP_READ, ROWS - 1, COLS - 1, 1'b0);
        send_item(OP_READ, 0, 0, 1'b1);
        send_item(OP_READ, ROWS - 1, 0, 1'b0);
        send_item(OP_READ, 0, COLS - 1, 1'b1);
        send_item(OP_WRITE, ROWS - 1, COLS - 1, 1'b0);
        send_item(OP_READ, ROWS - 1, COLS - 1, 1'b1);
    endtask

    // glider straddling the corner so neighbour lookups wrap across both edges
    task automatic test_wrap_glider();
        send_item(OP_CLEAR, 21, 42, 1'b1);
        send_item(OP_WRITE, ROWS - 2, COLS - 1, 1'b1);
        send_item(OP_WRITE, ROWS - 1, 0, 1'b1);
        send_item(OP_WRITE, 0, COLS - 2, 1'b1);
        send_item(OP_WRITE, 0, COLS - 1, 1'b1);
        send_item(OP_WRITE, 0, 0, 1'b1);
        send_item(OP_STEP, 0, 0, 1'b0);
        send_item(OP_STEP, ROWS - 1, COLS - 1, 1'b1);
        send_item(OP_READ, ROWS - 1, 0, 1'b0);
        send_item(OP_READ, 0, 0, 1'b0);
        send_item(OP_READ, 0, 1, 1'b0);
    endtask

    task automatic test_back_to_back();
        int rows_used [8];
        int cols_used [8];
        steady_flow = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            rows_used[i] = $urandom_range(0, ROWS - 1);
            cols_used[i] = $urandom_range(0, COLS - 1);
            send_item(OP_WRITE, rows_used[i], cols_used[i], 1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < 8; i++)
            send_item(OP_READ, rows_used[i], cols_used[i], 1'($urandom_range(0, 1)));
        send_item(OP_STEP, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1), 1'b0);
        // hold off until the board has answered everything
        wait_drained();
        steady_flow = 1'b0;
        for (int i = 0; i < 4; i++)
            send_item(OP_READ, rows_used[i], cols_used[i], 1'b0);
    endtask

    // clusters of live cells, one or two generations, then reads over the
    // neighbourhood; some stray items of any kind in between
    task automatic test_random_patterns();
        int first_item;
        int base_r;
        int base_c;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            base_r = $urandom_range(0, ROWS - 1);
            base_c = $urandom_range(0, COLS - 1);
            if ($urandom_range(0, 99) < 20)
                send_item(OP_CLEAR, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                          1'($urandom_range(0, 1)));
            repeat ($urandom_range(8, 14))
                send_item(OP_WRITE, (base_r + $urandom_range(0, 4)) % ROWS,
                          (base_c + $urandom_range(0, 4)) % COLS, $urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2))
                send_item(OP_STEP, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                          1'($urandom_range(0, 1)));
            repeat ($urandom_range(4, 8))
                send_item(OP_READ, (base_r + ROWS - 1 + $urandom_range(0, 6)) % ROWS,
                          (base_c + COLS - 1 + $urandom_range(0, 6)) % COLS,
                          1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2))
                send_item(OPCODE_W'($urandom_range(0, 3)), $urandom_range(0, ROWS - 1),
                          $urandom_range(0, COLS - 1), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.opcode  <= OP_WRITE;
        req_ch.row     <= '0;
        req_ch.col     <= '0;
        req_ch.cell_in <= 1'b0;
        foreach (life_grid[r])
            life_grid[r] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_board();
        test_cell_access();
        test_wrap_glider();
        test_back_to_back();
        test_random_patterns();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d responses never arrived", pending_answers.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
